/* hdl/upud_pkg.sv */
// ----------------------------------------------------------------------------
// upud_pkg
// Shared types, character codes, code-point limits and hex helpers for the
// URL percent / percent-u decoder.
// ----------------------------------------------------------------------------
package upud_pkg;

   localparam int WIN_DEPTH  = 6;
   localparam int HOLD_DEPTH = 5;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 1;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_PLUS_TO_SPACE   = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_UNICODE_ESCAPES = 1'd1;

   // Character codes.
   localparam logic [7:0] CHAR_PERCENT = 8'h25;
   localparam logic [7:0] CHAR_PLUS    = 8'h2B;
   localparam logic [7:0] CHAR_SPACE   = 8'h20;
   localparam logic [7:0] CHAR_LOWER_U = 8'h75;
   localparam logic [7:0] CHAR_UPPER_U = 8'h55;

   // Code-point mapping and UTF-8 constants.
   localparam logic [15:0] FULLWIDTH_LO  = 16'hFF01;
   localparam logic [15:0] FULLWIDTH_HI  = 16'hFF5E;
   localparam logic [15:0] FULLWIDTH_OFS = 16'hFEE0;
   localparam logic [15:0] IDEO_SPACE    = 16'h3000;
   localparam logic [15:0] UTF8_ONE_LIM  = 16'h0080;
   localparam logic [15:0] UTF8_TWO_LIM  = 16'h0800;
   localparam logic [7:0]  UTF8_CONT     = 8'h80;
   localparam logic [7:0]  UTF8_LEAD2    = 8'hC0;
   localparam logic [7:0]  UTF8_LEAD3    = 8'hE0;
   localparam logic [7:0]  UTF8_MASK6    = 8'h3F;

   localparam logic [2:0] ADV_ONE   = 3'd1;
   localparam logic [2:0] ADV_BYTE  = 3'd3;
   localparam logic [2:0] ADV_UNI   = 3'd6;

   typedef logic [WIN_DEPTH-1:0][7:0] win_type;

   typedef enum logic [2:0] {
      ACT_LIT,
      ACT_FAIL,
      ACT_BYTE,
      ACT_UNI,
      ACT_WAIT
   } act_kind_type;

   // Decision for the byte at the head of the window.
   typedef struct packed {
      act_kind_type    kind;
      logic [1:0]      nbytes;
      logic [2:0]      adv;
      logic [2:0][7:0] bytes;
   } act_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH
   } state_type;

   function automatic logic is_hex(input logic [7:0] c);
      return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66) ||
             (c >= 8'h41 && c <= 8'h46);
   endfunction

   function automatic logic [3:0] hex_val(input logic [7:0] c);
      logic [7:0] v;
      v = 8'h00;
      if (c >= 8'h30 && c <= 8'h39) begin
         v = c - 8'h30;
      end else if (c >= 8'h61 && c <= 8'h66) begin
         v = c - 8'h57;
      end else if (c >= 8'h41 && c <= 8'h46) begin
         v = c - 8'h37;
      end
      return v[3:0];
   endfunction

endpackage

/* hdl/upud_ifs.sv */
// ----------------------------------------------------------------------------
// upud_ifs
// Valid/ready channel interfaces for the decoder's raw byte input and its
// decoded byte output.
// ----------------------------------------------------------------------------
interface upud_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       in_last;

   modport source (output valid, output in_byte, output in_last, input ready);
   modport sink (input valid, input in_byte, input in_last, output ready);
endinterface

interface upud_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       run_last;
   logic       stream_last;

   modport source (output valid, output out_byte, output run_last, output stream_last,
                   input ready);
   modport sink (input valid, input out_byte, input run_last, input stream_last,
                 output ready);
endinterface

/* hdl/upud_judge.sv */
// ----------------------------------------------------------------------------
// upud_judge
// Decides what the byte at the head of the decode window turns into:
// a literal ('+' optionally as a space), a failed escape, a %HH byte, a %uHHHH
// code point in UTF-8 after the fullwidth and space mapping, or a wait for more input.
// ----------------------------------------------------------------------------
module upud_judge (
   input  upud_pkg::win_type win,
   input  logic [2:0]        rem,
   input  logic              plus_to_space,
   input  logic              unicode_escapes,
   input  logic              last,
   output upud_pkg::act_type act
);

   logic        hx1, hx2, hx3, hx4, hx5;
   logic        is_u;
   logic        bad_digit;
   logic [15:0] cp;
   logic [15:0] mapped;

   always_comb begin
      hx1 = upud_pkg::is_hex(win[1]);
      hx2 = upud_pkg::is_hex(win[2]);
      hx3 = upud_pkg::is_hex(win[3]);
      hx4 = upud_pkg::is_hex(win[4]);
      hx5 = upud_pkg::is_hex(win[5]);
      is_u = unicode_escapes &&
             (win[1] == upud_pkg::CHAR_LOWER_U || win[1] == upud_pkg::CHAR_UPPER_U);
      // Only digits that have already arrived can fail a percent-u escape.
      bad_digit = (rem > 3'd2 && !hx2) || (rem > 3'd3 && !hx3) ||
                  (rem > 3'd4 && !hx4) || (rem > 3'd5 && !hx5);
      cp = {upud_pkg::hex_val(win[2]), upud_pkg::hex_val(win[3]),
            upud_pkg::hex_val(win[4]), upud_pkg::hex_val(win[5])};

      if (cp >= upud_pkg::FULLWIDTH_LO && cp <= upud_pkg::FULLWIDTH_HI) begin
         mapped = cp - upud_pkg::FULLWIDTH_OFS;
      end else if (cp == upud_pkg::IDEO_SPACE) begin
         mapped = {8'h00, upud_pkg::CHAR_SPACE};
      end else begin
         mapped = cp;
      end

      act.kind   = upud_pkg::ACT_FAIL;
      act.nbytes = 2'd1;
      act.adv    = upud_pkg::ADV_ONE;
      act.bytes  = '0;

      if (win[0] != upud_pkg::CHAR_PERCENT) begin
         act.kind = upud_pkg::ACT_LIT;
      end else if (rem < 3'd2) begin
         act.kind = upud_pkg::ACT_WAIT;
      end else if (hx1) begin
         if (rem < 3'd3) begin
            act.kind = upud_pkg::ACT_WAIT;
         end else if (hx2) begin
            act.kind = upud_pkg::ACT_BYTE;
         end
      end else if (is_u && !bad_digit) begin
         act.kind = (rem < 3'd6) ? upud_pkg::ACT_WAIT : upud_pkg::ACT_UNI;
      end

      // At the end of the stream an undecided escape fails.
      if (act.kind == upud_pkg::ACT_WAIT && last) begin
         act.kind = upud_pkg::ACT_FAIL;
      end

      case (act.kind)
         upud_pkg::ACT_LIT: begin
            act.bytes[0] = (plus_to_space && win[0] == upud_pkg::CHAR_PLUS) ?
                           upud_pkg::CHAR_SPACE : win[0];
         end
         upud_pkg::ACT_BYTE: begin
            act.adv      = upud_pkg::ADV_BYTE;
            act.bytes[0] = {upud_pkg::hex_val(win[1]), upud_pkg::hex_val(win[2])};
         end
         upud_pkg::ACT_UNI: begin
            act.adv = upud_pkg::ADV_UNI;
            if (mapped < upud_pkg::UTF8_ONE_LIM) begin
               act.bytes[0] = mapped[7:0];
            end else if (mapped < upud_pkg::UTF8_TWO_LIM) begin
               act.nbytes   = 2'd2;
               act.bytes[0] = upud_pkg::UTF8_LEAD2 | {3'b000, mapped[10:6]};
               act.bytes[1] = upud_pkg::UTF8_CONT | ({2'b00, mapped[5:0]} &
                                                     upud_pkg::UTF8_MASK6);
            end else begin
               act.nbytes   = 2'd3;
               act.bytes[0] = upud_pkg::UTF8_LEAD3 | {4'h0, mapped[15:12]};
               act.bytes[1] = upud_pkg::UTF8_CONT | {2'b00, mapped[11:6]};
               act.bytes[2] = upud_pkg::UTF8_CONT | ({2'b00, mapped[5:0]} &
                                                     upud_pkg::UTF8_MASK6);
            end
         end
         upud_pkg::ACT_WAIT: begin
            act.adv = 3'd0;
         end
         default: begin
            act.bytes[0] = upud_pkg::CHAR_PERCENT;
         end
      endcase
   end

endmodule

/* hdl/url_percent_unicode_decoder.sv */
// Sequence: the accepted byte is joined to the held escape bytes, then each decoded byte is
// produced in turn, then a pending escape is held or the window is found empty, and a closing
// state hands on the last byte; a stalled output holds up this sequence.
// Throughput: one item at a time, set by the single decision unit, and one output byte per
// cycle while the output is not stalled. Synchronous active-high reset clears the held escape
// and sets both configuration bits to 1.
// ----------------------------------------------------------------------------
// url_percent_unicode_decoder
// Streaming URL decoder for %HH, optional '+' to space and optional %uHHHH
// escapes, one raw byte per transaction in, one decoded byte per transaction out.
// ----------------------------------------------------------------------------
module url_percent_unicode_decoder (
   input  logic                                clock,
   input  logic                                reset,
   upud_req_if.sink                            req_ch,
   upud_rsp_if.source                          rsp_ch,
   input  logic                                csr_we,
   input  logic [upud_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [upud_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   upud_pkg::state_type state_ff, state_in;
   upud_pkg::win_type   win_ff;
   upud_pkg::act_type   act;

   logic       plus_ff, uni_ff;
   logic [2:0] rem_ff;
   logic [2:0] held_count_ff;
   logic       last_ff;
   logic [1:0] sub_ff;
   logic       pend_valid_ff;
   logic [7:0] pend_byte_ff;
   logic       rsp_valid_ff;
   logic [7:0] rsp_byte_ff;
   logic       rsp_run_last_ff;
   logic       rsp_stream_last_ff;

   logic out_free;
   logic accept, produce, advance, hold, flush, push;

   upud_judge u_judge (
      .win             (win_ff),
      .rem             (rem_ff),
      .plus_to_space   (plus_ff),
      .unicode_escapes (uni_ff),
      .last            (last_ff),
      .act             (act)
   );

   assign out_free           = !rsp_valid_ff || rsp_ch.ready;
   assign req_ch.ready       = (state_ff == upud_pkg::ST_IDLE);
   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.out_byte    = rsp_byte_ff;
   assign rsp_ch.run_last    = rsp_run_last_ff;
   assign rsp_ch.stream_last = rsp_stream_last_ff;
   assign push               = (produce && pend_valid_ff) || flush;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         upud_pkg::ST_IDLE: begin
            if (req_ch.valid) state_in = upud_pkg::ST_SCAN;
         end
         upud_pkg::ST_SCAN: begin
            if (rem_ff == 3'd0 || act.kind == upud_pkg::ACT_WAIT) begin
               state_in = upud_pkg::ST_FINISH;
            end
         end
         upud_pkg::ST_FINISH: begin
            if (!pend_valid_ff || out_free) state_in = upud_pkg::ST_IDLE;
         end
         default: state_in = upud_pkg::ST_IDLE;
      endcase
   end

   // Sequencer controls. The newest decoded byte waits in the pending register
   // until it is known whether it is the last one of the transaction.
   always_comb begin
      accept  = 1'b0;
      produce = 1'b0;
      advance = 1'b0;
      hold    = 1'b0;
      flush   = 1'b0;
      case (state_ff)
         upud_pkg::ST_IDLE: begin
            accept = req_ch.valid;
         end
         upud_pkg::ST_SCAN: begin
            if (rem_ff != 3'd0) begin
               if (act.kind == upud_pkg::ACT_WAIT) begin
                  hold = 1'b1;
               end else if (!pend_valid_ff || out_free) begin
                  produce = 1'b1;
                  advance = (sub_ff == act.nbytes - 2'd1);
               end
            end
         end
         upud_pkg::ST_FINISH: begin
            flush = pend_valid_ff && out_free;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= upud_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         plus_ff <= 1'b1;
         uni_ff  <= 1'b1;
      end else if (csr_we) begin
         case (csr_index)
            upud_pkg::CSR_PLUS_TO_SPACE:   plus_ff <= csr_wdata[0];
            upud_pkg::CSR_UNICODE_ESCAPES: uni_ff  <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // Decode window: held escape bytes followed by the new byte.
   always_ff @(posedge clock) begin
      if (accept) begin
         win_ff[held_count_ff] <= req_ch.in_byte;
         last_ff               <= req_ch.in_last;
      end else if (advance) begin
         win_ff <= win_ff >> {act.adv, 3'b000};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rem_ff        <= 3'd0;
         held_count_ff <= 3'd0;
         sub_ff        <= 2'd0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (accept) begin
            rem_ff        <= held_count_ff + 3'd1;
            held_count_ff <= 3'd0;
            sub_ff        <= 2'd0;
         end else if (hold) begin
            held_count_ff <= rem_ff;
         end else if (advance) begin
            rem_ff <= rem_ff - act.adv;
            sub_ff <= 2'd0;
         end else if (produce) begin
            sub_ff <= sub_ff + 2'd1;
         end

         if (produce) begin
            pend_valid_ff <= 1'b1;
         end else if (flush) begin
            pend_valid_ff <= 1'b0;
         end

         if (push) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (produce) begin
         pend_byte_ff <= act.bytes[sub_ff];
      end
      if (push) begin
         rsp_byte_ff        <= pend_byte_ff;
         rsp_run_last_ff    <= flush;
         rsp_stream_last_ff <= flush && last_ff;
      end
   end

   // A held escape never exceeds the hold depth.
   assert property (@(posedge clock) disable iff (reset)
      held_count_ff <= 3'(upud_pkg::HOLD_DEPTH))
      else $error("held escape longer than the hold depth");

   // Every transaction's last byte has been handed on before the next is taken.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == upud_pkg::ST_IDLE) |-> !pend_valid_ff)
      else $error("pending byte left behind when idle");

   // The final byte of a stream leaves nothing held.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == upud_pkg::ST_FINISH && last_ff) |-> (held_count_ff == 3'd0))
      else $error("escape held past the end of the stream");

   // The UTF-8 byte counter stays within the current decision.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == upud_pkg::ST_SCAN && rem_ff != 3'd0 &&
       act.kind != upud_pkg::ACT_WAIT) |-> (sub_ff < act.nbytes))
      else $error("byte counter ran past the decoded sequence");

endmodule
